### design/ster_pkg.sv
// ----------------------------------------------------------------------------
// ster_pkg
// Shared constants and types for the sorted table equal-range search block.
// ----------------------------------------------------------------------------
package ster_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 10;
	localparam int COUNT_REG_W = 11;
	localparam int RES_IDX_W   = 11;

	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Operation codes of an input item
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Register indexes
	localparam logic REG_ENTRY_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LB,
		ST_HIT,
		ST_UB,
		ST_DONE
	} ster_state_t;

endpackage

### design/sorted_table_equal_range.sv
// ----------------------------------------------------------------------------
// sorted_table_equal_range
// Table of signed 32-bit words with lower/upper bound search per query item.
// ----------------------------------------------------------------------------
// A load item writes one table entry and gives no result.
// A query item runs a lower-bound binary search, one read of the check entry,
// and an upper-bound binary search starting at the first match, over a
// single-port table memory with a registered read. Each search step is one
// memory read plus compare. A query passes through the accept, the
// lower-bound steps, the check-entry read, the upper-bound steps and a
// hand-over of the result to the output register. The hand-over waits
// while the output register holds an item that has not been taken. A new item
// is taken once the running query has moved its result into the output
// register. The table has no reset; entries must be loaded before a query can
// reach them.
// ----------------------------------------------------------------------------
module sorted_table_equal_range
	import ster_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [IDX_W-1:0]            entry_index,
	input  logic signed [DATA_W-1:0]    value,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic signed [RES_IDX_W-1:0] first_index,
	output logic signed [RES_IDX_W-1:0] last_index,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [PADDR_W-1:0]          paddr,
	input  logic [PDATA_W-1:0]          pwdata,
	output logic [PDATA_W-1:0]          prdata,
	output logic                        pready
);

	logic [DATA_W-1:0]      table_mem [TABLE_DEPTH];
	logic [DATA_W-1:0]      rd_data_s1;

	ster_state_t            state_q, state_d;
	logic [COUNT_REG_W-1:0] entry_count_q;
	logic [CNT_W-1:0]       n_q, n_cur;
	logic [CNT_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [CNT_W-1:0]       first_q, first_d, last_q, last_d;
	logic                   hit_q, hit_d;
	logic signed [DATA_W-1:0] target_q;

	logic                   in_acc, query_acc, mem_we;
	logic                   rd_en;
	logic [CNT_W-1:0]       rd_idx;
	logic                   out_load;

	logic                   e_lt_t, t_lt_e, go_right, step_more;
	logic [CNT_W-1:0]       step_lo, step_hi, step_mid, ub_mid;

	// ---------------- configuration port ----------------
	logic cfg_we;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_we  = psel && penable && pwrite && pready && (reg_sel == REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= pwdata[COUNT_REG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_ENTRY_COUNT) begin
			prdata = PDATA_W'(entry_count_q);
		end
	end

	// Saturate the count at the table depth
	always_comb begin
		if (32'(entry_count_q) > TABLE_DEPTH) begin
			n_cur = CNT_W'(TABLE_DEPTH);
		end else begin
			n_cur = CNT_W'(entry_count_q);
		end
	end

	// ---------------- input side ----------------
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign query_acc = in_acc && (operation == OP_QUERY);
	assign mem_we    = in_acc && (operation == OP_LOAD) && (32'(entry_index) < TABLE_DEPTH);

	// Writes happen only in idle, reads only during a query: no same-entry overlap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[ADDR_W'(entry_index)] <= value;
		end
		if (rd_en) begin
			rd_data_s1 <= table_mem[rd_idx[ADDR_W-1:0]];
		end
	end

	// ---------------- search step ----------------
	assign e_lt_t    = $signed(rd_data_s1) < target_q;
	assign t_lt_e    = target_q < $signed(rd_data_s1);
	assign go_right  = (state_q == ST_UB) ? !t_lt_e : e_lt_t;
	assign step_lo   = go_right ? (mid_q + CNT_W'(1)) : lo_q;
	assign step_hi   = go_right ? hi_q : mid_q;
	assign step_mid  = step_lo + ((step_hi - step_lo) >> 1);
	assign step_more = step_lo < step_hi;
	assign ub_mid    = first_q + ((n_q - first_q) >> 1);

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		first_d  = first_q;
		last_d   = last_q;
		hit_d    = hit_q;
		rd_en    = 1'b0;
		rd_idx   = mid_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					lo_d  = '0;
					hi_d  = n_cur;
					hit_d = 1'b0;
					if (n_cur == '0) begin
						state_d = ST_DONE;
					end else begin
						mid_d   = n_cur >> 1;
						rd_en   = 1'b1;
						rd_idx  = n_cur >> 1;
						state_d = ST_LB;
					end
				end
			end
			ST_LB: begin
				lo_d = step_lo;
				hi_d = step_hi;
				if (step_more) begin
					mid_d  = step_mid;
					rd_en  = 1'b1;
					rd_idx = step_mid;
				end else begin
					first_d = step_lo;
					if (step_lo < n_q) begin
						rd_en   = 1'b1;
						rd_idx  = step_lo;
						state_d = ST_HIT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_HIT: begin
				if ($signed(rd_data_s1) == target_q) begin
					// Upper bound cannot lie before the first match
					hit_d   = 1'b1;
					lo_d    = first_q;
					hi_d    = n_q;
					mid_d   = ub_mid;
					rd_en   = 1'b1;
					rd_idx  = ub_mid;
					state_d = ST_UB;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_UB: begin
				lo_d = step_lo;
				hi_d = step_hi;
				if (step_more) begin
					mid_d  = step_mid;
					rd_en  = 1'b1;
					rd_idx = step_mid;
				end else begin
					last_d  = (step_lo > first_q) ? (step_lo - CNT_W'(1)) : first_q;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hold until the output register is free
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		first_q <= first_d;
		last_q  <= last_d;
		hit_q   <= hit_d;
		if (query_acc) begin
			target_q <= value;
			n_q      <= n_cur;
		end
	end

	// ---------------- output register ----------------
	logic                        out_valid_q;
	logic                        found_q;
	logic signed [RES_IDX_W-1:0] first_index_q, last_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q       <= hit_q;
			first_index_q <= hit_q ? RES_IDX_W'(first_q) : '1;
			last_index_q  <= hit_q ? RES_IDX_W'(last_q) : '1;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign first_index = first_index_q;
	assign last_index  = last_index_q;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted table equal-range search block.
// ----------------------------------------------------------------------------
// Loads ascending tables of several sizes and shapes: dense runs of duplicates,
// wide spreads, and tables that span the full signed range. It sets the entry
// count over the APB port and sends query items for targets that are present,
// absent, next to present ones, or held only past the count. A shadow copy of
// the table and count predicts found, first and last index for each query.
// Every result is compared in order with its prediction. Both handshakes stall
// at random, with stretches that do not stall.
// ----------------------------------------------------------------------------
module tb;
	import ster_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SMALL_ITEMS   = 100;
	localparam int REPORT_CAP    = 200;
	localparam int REG_SPARE     = 1;
	localparam int COUNT_MAX     = (1 << COUNT_REG_W) - 1;

	localparam logic signed [DATA_W-1:0]    BOTTOM_WORD = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0]    TOP_WORD    = 32'sh7FFF_FFFF;
	localparam logic signed [RES_IDX_W-1:0] NO_INDEX    = -1;

	typedef struct packed {
		logic                        found;
		logic signed [RES_IDX_W-1:0] first_index;
		logic signed [RES_IDX_W-1:0] last_index;
	} range_t;

	class range_ledger;
		bit signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
		logic [COUNT_REG_W-1:0] shadow_count;
		range_t                 awaited_ranges [$];
		int                     errors;
		int                     results_seen;

		function new();
			shadow_count = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_register(int unsigned index, logic [PDATA_W-1:0] data);
			if (index == REG_ENTRY_COUNT)
				shadow_count = data[COUNT_REG_W-1:0];
		endfunction

		function int pending();
			return awaited_ranges.size();
		endfunction

		// first index in [0, n) whose entry is >= t, or > t when past_equal is set; n if none
		function int unsigned bound_of(int unsigned n, bit signed [DATA_W-1:0] t,
				bit past_equal);
			int unsigned lo, hi, mid;
			bit          go_right;
			lo = 0;
			hi = n;
			while (lo < hi) begin
				mid = lo + ((hi - lo) >> 1);
				go_right = past_equal ? (shadow_table[mid] <= t) : (shadow_table[mid] < t);
				if (go_right)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function void note_item(logic op, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] v);
			int unsigned n, lower, upper;
			range_t      r;
			if (op == OP_LOAD) begin
				shadow_table[idx] = v;
				return;
			end
			n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
			lower = bound_of(n, v, 1'b0);
			if (lower < n && shadow_table[lower] == v) begin
				upper = bound_of(n, v, 1'b1);
				r.found = 1'b1;
				r.first_index = RES_IDX_W'(lower);
				r.last_index = (upper > lower) ? RES_IDX_W'(upper - 1) : RES_IDX_W'(lower);
			end else begin
				r.found = 1'b0;
				r.first_index = NO_INDEX;
				r.last_index = NO_INDEX;
			end
			awaited_ranges.push_back(r);
		endfunction

		task report(input string msg);
			if (errors < REPORT_CAP)
				$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_range(input logic f, input logic signed [RES_IDX_W-1:0] lo_i,
				input logic signed [RES_IDX_W-1:0] hi_i);
			range_t want;
			results_seen++;
			if (awaited_ranges.size() == 0) begin
				report($sformatf("result %0d with no query waiting: found=%0b first=%0d last=%0d",
					results_seen, f, lo_i, hi_i));
				return;
			end
			want = awaited_ranges.pop_front();
			if (f !== want.found || lo_i !== want.first_index || hi_i !== want.last_index)
				report($sformatf("result %0d: got found=%0b first=%0d last=%0d, want %0b %0d %0d",
					results_seen, f, lo_i, hi_i, want.found, want.first_index, want.last_index));
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid;
	logic                        in_ready;
	logic                        operation;
	logic [IDX_W-1:0]            entry_index;
	logic signed [DATA_W-1:0]    value;
	logic                        out_valid;
	logic                        out_ready;
	logic                        found;
	logic signed [RES_IDX_W-1:0] first_index;
	logic signed [RES_IDX_W-1:0] last_index;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [PADDR_W-1:0]          paddr;
	logic [PDATA_W-1:0]          pwdata;
	logic [PDATA_W-1:0]          prdata;
	logic                        pready;

	range_ledger            ledger;
	bit signed [DATA_W-1:0] sorted_plan [TABLE_DEPTH];
	bit                     in_idle_on;
	bit                     out_idle_on;
	int                     item_total;
	int                     cycle_count;

	sorted_table_equal_range dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.entry_index (entry_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.first_index (first_index),
		.last_index  (last_index),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_range(found, first_index, last_index);
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("sorted_table_equal_range regression: fail");
			$finish;
		end
	end

	// result side: in random stretches, stall for a random time before taking each item
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		out_ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 32 == 0)
				out_idle_on = ($urandom_range(0, 2) != 0);
			stall = out_idle_on ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] v);
		int unsigned gap;
		gap = in_idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.note_item(op, idx, v);
		item_total++;
	endtask

	// drop valid, wait for every result, then let the block go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int unsigned index, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(index * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_register(index, data);
	endtask

	// ascending words: dense runs of duplicates, a wide spread, or the full range
	task automatic plan_table(input int n);
		longint      cur, inc, step;
		int unsigned style, r;
		if (n == 0)
			return;
		style = $urandom_range(0, 2);
		step = 64'd4294967296 / (n + 1);
		case (style)
			0: cur = longint'($urandom_range(0, 40)) - 20;
			1: cur = longint'(BOTTOM_WORD) + longint'($urandom_range(0, 32'(step)));
			default: cur = longint'(BOTTOM_WORD);
		endcase
		for (int i = 0; i < n; i++) begin
			sorted_plan[i] = DATA_W'(cur);
			r = $urandom_range(0, 9);
			if (r < 3)
				inc = 0;
			else if (style == 0)
				inc = $urandom_range(1, 2);
			else
				inc = $urandom_range(1, (step > 64'd2147483647) ? 32'hFFFF_FFFF : 32'(2 * step));
			cur = (cur + inc > longint'(TOP_WORD)) ? longint'(TOP_WORD) : cur + inc;
		end
		if (style == 2)
			sorted_plan[n-1] = TOP_WORD;
	endtask

	task automatic load_table(input int n);
		int unsigned spill;
		plan_table(n);
		in_idle_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			// overwrite at random: a stale word first, then the planned one
			if ($urandom_range(0, 7) == 0)
				send_item(OP_LOAD, IDX_W'(i), $urandom());
			send_item(OP_LOAD, IDX_W'(i), sorted_plan[i]);
		end
		// junk past the planned range never reaches a query
		spill = (n < TABLE_DEPTH) ? $urandom_range(0, 3) : 0;
		repeat (spill)
			send_item(OP_LOAD, IDX_W'($urandom_range(n, TABLE_DEPTH - 1)), $urandom());
	endtask

	function automatic logic signed [DATA_W-1:0] pick_target(input int unsigned used);
		int unsigned              r, k;
		logic signed [DATA_W-1:0] w;
		r = $urandom_range(0, 19);
		if (used != 0 && r < 12) begin
			w = ledger.shadow_table[$urandom_range(0, used - 1)];
			if (r < 9)
				return w;
			return r[0] ? w + 1 : w - 1;
		end
		if (r < 14 && used < TABLE_DEPTH) begin
			k = $urandom_range(used, (used + 8 < TABLE_DEPTH) ? used + 8 : TABLE_DEPTH - 1);
			return ledger.shadow_table[k];
		end
		if (r < 17) begin
			case ($urandom_range(0, 3))
				0: return BOTTOM_WORD;
				1: return TOP_WORD;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom();
	endfunction

	task automatic query_burst(input int unsigned count, input int queries);
		int unsigned used;
		used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		in_idle_on = ($urandom_range(0, 3) != 0);
		repeat (queries) begin
			if ($urandom_range(0, 24) == 0)
				settle_block();
			send_item(OP_QUERY, IDX_W'($urandom()), pick_target(used));
		end
	endtask

	task automatic run_directed();
		bit signed [DATA_W-1:0] seed_vals [8];
		seed_vals = '{BOTTOM_WORD, BOTTOM_WORD, -5, 0, 0, 0, 7, TOP_WORD};
		in_idle_on = 1'b0;
		for (int i = 0; i < 8; i++)
			send_item(OP_LOAD, IDX_W'(i), seed_vals[i]);
		// top index holds a word that lies past the count
		send_item(OP_LOAD, '1, 32'sh5A5A_A5A5);
		settle_block();
		write_reg(REG_ENTRY_COUNT, 8);
		in_idle_on = 1'b1;
		send_item(OP_QUERY, '0, BOTTOM_WORD);
		send_item(OP_QUERY, '1, TOP_WORD);
		send_item(OP_QUERY, 10'h155, 0);
		send_item(OP_QUERY, 10'h2AA, -5);
		send_item(OP_QUERY, '0, 7);
		send_item(OP_QUERY, '0, 1);
		send_item(OP_QUERY, '0, -6);
		send_item(OP_QUERY, '0, 32'sh5A5A_A5A5);
		settle_block();
		// unmapped register: the count must stay at eight
		write_reg(REG_SPARE, '1);
		send_item(OP_QUERY, '0, 0);
		settle_block();
		write_reg(REG_ENTRY_COUNT, 0);
		send_item(OP_QUERY, '0, BOTTOM_WORD);
		settle_block();
		write_reg(REG_ENTRY_COUNT, 3);
		send_item(OP_QUERY, '0, BOTTOM_WORD);
		send_item(OP_QUERY, '0, 0);
		settle_block();
	endtask

	initial begin
		int          n;
		int unsigned count;
		in_valid <= 1'b0;
		operation <= OP_LOAD;
		entry_index <= '0;
		value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		ledger = new();
		item_total = 0;
		cycle_count = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		while (item_total < SMALL_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 300) : $urandom_range(0, 48);
			load_table(n);
			settle_block();
			count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
			write_reg(REG_ENTRY_COUNT, count);
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_SPARE, $urandom());
			query_burst(count, $urandom_range(12, 40));
			settle_block();
		end

		// full table, then counts at and past the depth
		load_table(TABLE_DEPTH);
		settle_block();
		write_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
		query_burst(TABLE_DEPTH, 50);
		settle_block();
		write_reg(REG_ENTRY_COUNT, COUNT_MAX);
		query_burst(COUNT_MAX, 30);
		settle_block();
		count = $urandom_range(TABLE_DEPTH + 1, COUNT_MAX - 1);
		write_reg(REG_ENTRY_COUNT, count);
		query_burst(count, 30);
		settle_block();

		if (ledger.errors == 0)
			$display("sorted_table_equal_range regression: pass");
		else
			$display("sorted_table_equal_range regression: fail");
		$finish;
	end

endmodule

### sorted_table_equal_range.f
design/ster_pkg.sv
design/sorted_table_equal_range.sv
verif/tb.sv
